@@ design/lkv_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Shared widths, codes, entry and cell control types, and a saturating counter helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

  localparam int HANDLE_W      = 32;
  localparam int LEN_W         = 12;
  localparam int COUNT_W       = 32;
  localparam int ENTRY_COUNT_W = 8;
  // Position bus wide enough for the largest supported capacity (1024)
  localparam int LIMIT_W       = 10;
  localparam int DEF_CAPACITY  = 128;

  localparam logic [LEN_W-1:0] MAX_KEY_LEN_RST   = 12'd64;
  localparam logic [LEN_W-1:0] MAX_VALUE_LEN_RST = 12'd1024;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_SET    = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_DONE   = 2'd0,
    STS_MISS   = 2'd1,
    STS_REJECT = 2'd2
  } status_t;

  typedef enum logic {
    CFG_MAX_KEY_LEN   = 1'b0,
    CFG_MAX_VALUE_LEN = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  // Cell row actions: push moves entries towards the old end up to a limit,
  // pull closes a gap from the old end down to a limit.
  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_PUSH,
    ACT_PULL,
    ACT_CLEAR
  } act_t;

  typedef struct packed {
    logic                valid;
    logic [HANDLE_W-1:0] key;
    logic [HANDLE_W-1:0] value;
  } entry_t;

  typedef struct packed {
    act_t               act;
    logic [LIMIT_W-1:0] limit;
  } cell_ctl_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

endpackage

`default_nettype wire

@@ design/lkv_cell.sv @@
// ----------------------------------------------------------------------------
// LRU cache cell
// One slot of the recency-ordered row: holds an entry, compares its key and
// takes the entry of either neighbour when the row shifts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lkv_cell #(
  parameter int IDX = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lkv_pkg::cell_ctl_t            ctl,
  input  wire logic [lkv_pkg::HANDLE_W-1:0]  cmp_key,
  input  wire lkv_pkg::entry_t               left_i,
  input  wire lkv_pkg::entry_t               right_i,
  output lkv_pkg::entry_t                    ent_o,
  output logic                               match_o
);

  localparam logic [lkv_pkg::LIMIT_W-1:0] MY_POS = lkv_pkg::LIMIT_W'(IDX);

  logic                         valid_r, valid_nxt;
  logic [lkv_pkg::HANDLE_W-1:0] key_r, key_nxt;
  logic [lkv_pkg::HANDLE_W-1:0] value_r, value_nxt;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    unique case (ctl.act)
      lkv_pkg::ACT_HOLD: begin
      end
      lkv_pkg::ACT_PUSH: begin
        if (MY_POS <= ctl.limit) begin
          valid_nxt = left_i.valid;
          key_nxt   = left_i.key;
          value_nxt = left_i.value;
        end
      end
      lkv_pkg::ACT_PULL: begin
        if (MY_POS >= ctl.limit) begin
          valid_nxt = right_i.valid;
          key_nxt   = right_i.key;
          value_nxt = right_i.value;
        end
      end
      lkv_pkg::ACT_CLEAR: begin
        valid_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign ent_o.valid = valid_r;
  assign ent_o.key   = key_r;
  assign ent_o.value = value_r;
  assign match_o     = valid_r && (key_r == cmp_key);

endmodule

`default_nettype wire

@@ design/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// LRU key/value cache
// Fixed-capacity key/value table kept in least-recently-used order.
// ----------------------------------------------------------------------------
// Entries live in a row of CAPACITY cells ordered by recency: cell 0 holds
// the most recent entry and the valid cells always form a prefix of the row.
// Each operation passes a lookup state, for the parallel key compare across
// all cells (match position and value are registered), then an update state
// in which the row shifts by one place to reorder, insert, evict or close a
// gap, and the result is loaded into the output register. The update state
// waits while a previous result has not been taken; a new operation is
// accepted in that same update cycle, overlapping the last one's update.
// Valid bits are cleared by reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache #(
  parameter int CAPACITY = lkv_pkg::DEF_CAPACITY
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration
  input  wire logic                               cfg_we,
  input  wire logic                               cfg_index,
  input  wire logic [lkv_pkg::LEN_W-1:0]          cfg_wdata,
  // operations
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         in_op,
  input  wire logic [lkv_pkg::HANDLE_W-1:0]       in_key_handle,
  input  wire logic [lkv_pkg::HANDLE_W-1:0]       in_value_handle,
  input  wire logic [lkv_pkg::LEN_W-1:0]          in_key_length,
  input  wire logic [lkv_pkg::LEN_W-1:0]          in_value_length,
  // results
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [1:0]                              out_status,
  output logic [lkv_pkg::HANDLE_W-1:0]            out_value_out,
  output logic [lkv_pkg::COUNT_W-1:0]             out_hit_count,
  output logic [lkv_pkg::COUNT_W-1:0]             out_access_count,
  output logic [lkv_pkg::COUNT_W-1:0]             out_set_count,
  output logic [lkv_pkg::ENTRY_COUNT_W-1:0]       out_entry_count,
  output logic [lkv_pkg::COUNT_W-1:0]             out_eviction_count
);

  localparam int POS_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);
  localparam logic [lkv_pkg::LIMIT_W-1:0] LAST_POS = lkv_pkg::LIMIT_W'(CAPACITY - 1);

  // configuration registers
  logic [lkv_pkg::LEN_W-1:0] max_key_len_r;
  logic [lkv_pkg::LEN_W-1:0] max_value_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_key_len_r   <= lkv_pkg::MAX_KEY_LEN_RST;
      max_value_len_r <= lkv_pkg::MAX_VALUE_LEN_RST;
    end else if (cfg_we) begin
      unique case (lkv_pkg::cfg_idx_t'(cfg_index))
        lkv_pkg::CFG_MAX_KEY_LEN:   max_key_len_r   <= cfg_wdata;
        lkv_pkg::CFG_MAX_VALUE_LEN: max_value_len_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // control
  lkv_pkg::state_t state_r, state_nxt;
  logic            out_valid_r;
  logic            out_free;
  logic            in_xfer;
  logic            do_update;

  assign out_free = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lkv_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = lkv_pkg::ST_LOOKUP;
      end
      lkv_pkg::ST_LOOKUP: begin
        state_nxt = lkv_pkg::ST_UPDATE;
      end
      lkv_pkg::ST_UPDATE: begin
        if (out_free) state_nxt = in_valid ? lkv_pkg::ST_LOOKUP : lkv_pkg::ST_IDLE;
      end
      default: state_nxt = lkv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    do_update = 1'b0;
    unique case (state_r)
      lkv_pkg::ST_IDLE: begin
        // no transfer while reset is held
        in_ready = rst_n;
      end
      lkv_pkg::ST_LOOKUP: begin
      end
      lkv_pkg::ST_UPDATE: begin
        in_ready  = out_free;
        do_update = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lkv_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // captured operation
  lkv_pkg::op_t              op_r;
  logic [lkv_pkg::HANDLE_W-1:0] key_r;
  logic [lkv_pkg::HANDLE_W-1:0] val_r;
  logic [lkv_pkg::LEN_W-1:0]    klen_r;
  logic [lkv_pkg::LEN_W-1:0]    vlen_r;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r   <= lkv_pkg::op_t'(in_op);
      key_r  <= in_key_handle;
      val_r  <= in_value_handle;
      klen_r <= in_key_length;
      vlen_r <= in_value_length;
    end
  end

  // cell row
  lkv_pkg::entry_t   ents     [CAPACITY];
  lkv_pkg::entry_t   front_ent;
  lkv_pkg::entry_t   tail_ent;
  lkv_pkg::cell_ctl_t upd_ctl;
  lkv_pkg::cell_ctl_t cell_ctl;
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] valid_vec;

  assign tail_ent = '{valid: 1'b0, key: '0, value: '0};

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    lkv_cell #(
      .IDX (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (cell_ctl),
      .cmp_key (key_r),
      .left_i  ((g == 0) ? front_ent : ents[(g == 0) ? 0 : g - 1]),
      .right_i ((g == CAPACITY - 1) ? tail_ent : ents[(g == CAPACITY - 1) ? g : g + 1]),
      .ent_o   (ents[g]),
      .match_o (match_vec[g])
    );
    assign valid_vec[g] = ents[g].valid;
  end

  // match position and value; keys are unique, so OR-ing the hits is exact
  logic                         match_any;
  logic [POS_W-1:0]             match_pos;
  logic [lkv_pkg::HANDLE_W-1:0] match_val;

  always_comb begin
    match_any = 1'b0;
    match_pos = '0;
    match_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_vec[i]) begin
        match_any = 1'b1;
        match_pos = match_pos | POS_W'(i);
        match_val = match_val | ents[i].value;
      end
    end
  end

  logic                         hit_r;
  logic [POS_W-1:0]             hit_pos_r;
  logic [lkv_pkg::HANDLE_W-1:0] hit_value_r;

  always_ff @(posedge clk) begin
    if (state_r == lkv_pkg::ST_LOOKUP) begin
      hit_r       <= match_any;
      hit_pos_r   <= match_pos;
      hit_value_r <= match_val;
    end
  end

  // table update and counters
  logic [CNT_W-1:0]            held_r, held_nxt;
  logic [lkv_pkg::COUNT_W-1:0] hits_r, hits_nxt;
  logic [lkv_pkg::COUNT_W-1:0] acc_r, acc_nxt;
  logic [lkv_pkg::COUNT_W-1:0] sets_r, sets_nxt;
  logic [lkv_pkg::COUNT_W-1:0] evict_r, evict_nxt;
  lkv_pkg::status_t            status;
  logic [lkv_pkg::HANDLE_W-1:0] vout;
  logic                         reject;
  logic [lkv_pkg::LIMIT_W-1:0]  hit_limit;

  assign reject    = (klen_r > max_key_len_r) || (vlen_r > max_value_len_r);
  assign hit_limit = lkv_pkg::LIMIT_W'(hit_pos_r);

  always_comb begin
    status          = lkv_pkg::STS_DONE;
    vout            = '0;
    held_nxt        = held_r;
    hits_nxt        = hits_r;
    acc_nxt         = acc_r;
    sets_nxt        = sets_r;
    evict_nxt       = evict_r;
    upd_ctl.act     = lkv_pkg::ACT_HOLD;
    upd_ctl.limit   = '0;
    front_ent.valid = 1'b1;
    front_ent.key   = key_r;
    front_ent.value = val_r;
    unique case (op_r)
      lkv_pkg::OP_GET: begin
        acc_nxt = lkv_pkg::sat_inc(acc_r);
        if (hit_r) begin
          hits_nxt        = lkv_pkg::sat_inc(hits_r);
          vout            = hit_value_r;
          front_ent.value = hit_value_r;
          upd_ctl.act     = lkv_pkg::ACT_PUSH;
          upd_ctl.limit   = hit_limit;
        end else begin
          status = lkv_pkg::STS_MISS;
        end
      end
      lkv_pkg::OP_SET: begin
        if (reject) begin
          status = lkv_pkg::STS_REJECT;
        end else begin
          sets_nxt    = lkv_pkg::sat_inc(sets_r);
          upd_ctl.act = lkv_pkg::ACT_PUSH;
          if (hit_r) begin
            upd_ctl.limit = hit_limit;
          end else begin
            // push the whole row; a full row drops its oldest entry off the end
            upd_ctl.limit = LAST_POS;
            if (held_r == FULL_CNT) begin
              evict_nxt = lkv_pkg::sat_inc(evict_r);
            end else begin
              held_nxt = held_r + 1'b1;
            end
          end
        end
      end
      lkv_pkg::OP_DELETE: begin
        if (hit_r) begin
          upd_ctl.act   = lkv_pkg::ACT_PULL;
          upd_ctl.limit = hit_limit;
          held_nxt      = held_r - 1'b1;
        end else begin
          status = lkv_pkg::STS_MISS;
        end
      end
      lkv_pkg::OP_CLEAR: begin
        upd_ctl.act = lkv_pkg::ACT_CLEAR;
        held_nxt    = '0;
        hits_nxt    = '0;
        acc_nxt     = '0;
        sets_nxt    = '0;
        evict_nxt   = '0;
      end
      default: begin
      end
    endcase
  end

  assign cell_ctl = do_update ? upd_ctl : '{act: lkv_pkg::ACT_HOLD, limit: '0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      hits_r  <= '0;
      acc_r   <= '0;
      sets_r  <= '0;
      evict_r <= '0;
    end else if (do_update) begin
      held_r  <= held_nxt;
      hits_r  <= hits_nxt;
      acc_r   <= acc_nxt;
      sets_r  <= sets_nxt;
      evict_r <= evict_nxt;
    end
  end

  // output register
  logic [CNT_W+lkv_pkg::ENTRY_COUNT_W-1:0] held_ext;
  logic [1:0]                           out_status_r;
  logic [lkv_pkg::HANDLE_W-1:0]         out_value_r;
  logic [lkv_pkg::COUNT_W-1:0]          out_hits_r;
  logic [lkv_pkg::COUNT_W-1:0]          out_acc_r;
  logic [lkv_pkg::COUNT_W-1:0]          out_sets_r;
  logic [lkv_pkg::ENTRY_COUNT_W-1:0]    out_entries_r;
  logic [lkv_pkg::COUNT_W-1:0]          out_evict_r;

  assign held_ext = {{lkv_pkg::ENTRY_COUNT_W{1'b0}}, held_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_update) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      out_status_r  <= status;
      out_value_r   <= vout;
      out_hits_r    <= hits_nxt;
      out_acc_r     <= acc_nxt;
      out_sets_r    <= sets_nxt;
      out_entries_r <= held_ext[lkv_pkg::ENTRY_COUNT_W-1:0];
      out_evict_r   <= evict_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_value_out      = out_value_r;
  assign out_hit_count      = out_hits_r;
  assign out_access_count   = out_acc_r;
  assign out_set_count      = out_sets_r;
  assign out_entry_count    = out_entries_r;
  assign out_eviction_count = out_evict_r;

  // assertions
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= FULL_CNT)
    else $error("entry count above capacity");

  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(held_r))
    else $error("valid cells disagree with entry count");

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("valid cells do not form a prefix of the row");

  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lkv_pkg::ST_LOOKUP) |-> $onehot0(match_vec))
    else $error("key held in more than one cell");

  a_update_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lkv_pkg::ST_UPDATE && !out_free) |=>
      (state_r == lkv_pkg::ST_UPDATE && out_valid_r))
    else $error("update stage left while result still pending");

endmodule

`default_nettype wire
